>>> rtl/pn_pkg.sv
// Shared types and constants for the path normalizer.
// Operation codes, byte constants and control structs used by all rtl files.
// No dependencies.
`timescale 1ns / 1ps

package pn_pkg;

    localparam int PATH_BYTES_DEF = 512;
    localparam int MAX_DEPTH_DEF  = 256;

    localparam int          CL_W     = 10;
    localparam logic [9:0]  COMP_MAX = 10'd1023;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    // What the output stage needs to know about a read transaction.
    typedef struct packed {
        logic hit;   // index below the current length
        logic root;  // index 0, which always holds '/'
    } t_rd_info;

    // Stack memory commands from the control logic.
    typedef struct packed {
        logic push;   // write an entry at the current depth
        logic fetch;  // read the entry that becomes the new top after a pop
    } t_stk_ctl;

endpackage

>>> rtl/pn_store.sv
// Result byte store of the path normalizer.
// One write port and one read port with registered read data; uses pn_pkg.
`timescale 1ns / 1ps

module pn_store #(
    parameter int PATH_BYTES = pn_pkg::PATH_BYTES_DEF,
    parameter int AW         = $clog2(PATH_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import pn_pkg::*;

    logic [7:0] r_mem [PATH_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/pn_stack.sv
// Component start stack of the path normalizer.
// A memory of entries {slash before start, start position} with the top entry
// cached in a register so a pop never waits on the read latency; uses pn_pkg.
`timescale 1ns / 1ps

module pn_stack #(
    parameter int MAX_DEPTH = pn_pkg::MAX_DEPTH_DEF,
    parameter int EW        = 10,
    parameter int SIW       = $clog2(MAX_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pn_pkg::t_stk_ctl    i_ctl,
    input  logic [SIW-1:0]      i_wr_idx,
    input  logic [EW-1:0]       i_wr_data,
    input  logic [SIW-1:0]      i_rd_idx,
    output logic [EW-1:0]       o_top
);
    import pn_pkg::*;

    logic [EW-1:0] r_mem [MAX_DEPTH];
    logic [EW-1:0] r_q;
    logic [EW-1:0] r_top;
    logic          r_pend;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_ctl.fetch) begin
            r_q <= r_mem[i_rd_idx];
        end
    end

    // A pop starts a fetch of the entry below into the read register, which
    // then feeds the top register unless a push has replaced the top by then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_ctl.fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top <= i_wr_data;
        end else if (r_pend) begin
            r_top <= r_q;
        end
    end

    assign o_top = r_top;

endmodule

>>> rtl/pn_ctrl.sv
// Control and path state of the path normalizer.
// Decodes each transaction, updates position, depth and component state, and
// drives the store and stack memories; uses pn_pkg.
`timescale 1ns / 1ps

module pn_ctrl #(
    parameter int PATH_BYTES = pn_pkg::PATH_BYTES_DEF,
    parameter int MAX_DEPTH  = pn_pkg::MAX_DEPTH_DEF,
    parameter int AW         = $clog2(PATH_BYTES),
    parameter int WPW        = $clog2(PATH_BYTES + 1),
    parameter int SIW        = $clog2(MAX_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_operation,
    input  logic [7:0]          i_char_in,
    input  logic [AW-1:0]       i_read_index,
    // result store
    output logic                o_st_we,
    output logic [AW-1:0]       o_st_waddr,
    output logic [7:0]          o_st_wdata,
    output logic                o_st_re,
    // component stack
    output pn_pkg::t_stk_ctl    o_stk_ctl,
    output logic [SIW-1:0]      o_stk_wr_idx,
    output logic [WPW:0]        o_stk_wr_data,
    output logic [SIW-1:0]      o_stk_rd_idx,
    input  logic [WPW:0]        i_stk_top,
    // state seen by the output stage
    output logic [WPW-1:0]      o_length,
    output logic                o_overflow,
    output pn_pkg::t_rd_info    o_rd_info
);
    import pn_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = ((WPW > CL_W) ? WPW : CL_W) + 1;

    logic [WPW-1:0]  r_wp, n_wp, c_wp;
    logic [DW-1:0]   r_depth, n_depth, c_depth;
    logic [CL_W-1:0] r_cl, n_cl, c_cl;
    logic            r_dots, n_dots, c_dots;
    logic            r_done, n_done;
    logic            r_ovf, n_ovf, c_ovf;
    logic            r_ls, n_ls, c_ls;   // byte before the write position is '/'
    t_rd_info        r_rd, n_rd;

    t_op             op;
    logic [SW-1:0]   pos;
    logic            close_req;

    assign op = t_op'(i_operation);

    always_comb begin
        // A push after an end starts a fresh path.
        c_wp    = r_wp;
        c_depth = r_depth;
        c_cl    = r_cl;
        c_dots  = r_dots;
        c_ovf   = r_ovf;
        c_ls    = r_ls;
        if (op == OP_PUSH && r_done) begin
            c_wp    = WPW'(1);
            c_depth = '0;
            c_cl    = '0;
            c_dots  = 1'b1;
            c_ovf   = 1'b0;
            c_ls    = 1'b1;
        end

        n_wp      = c_wp;
        n_depth   = c_depth;
        n_cl      = c_cl;
        n_dots    = c_dots;
        n_ovf     = c_ovf;
        n_ls      = c_ls;
        n_done    = r_done;
        n_rd      = '0;
        close_req = 1'b0;

        pos          = SW'(c_wp) + SW'(c_cl);
        o_st_we      = 1'b0;
        o_st_waddr   = pos[AW-1:0];
        o_st_wdata   = i_char_in;
        o_st_re      = 1'b0;
        o_stk_ctl    = '0;
        o_stk_wr_idx = c_depth[SIW-1:0];
        o_stk_wr_data = {c_ls, c_wp};
        o_stk_rd_idx = SIW'(c_depth - DW'(2));

        case (op)
            OP_PUSH: begin
                n_done = 1'b0;
                if (i_char_in == CHAR_SLASH) begin
                    close_req = 1'b1;
                end else if (c_cl >= COMP_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    if (pos < SW'(PATH_BYTES)) begin
                        o_st_we = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cl = c_cl + CL_W'(1);
                    if (i_char_in != CHAR_DOT) begin
                        n_dots = 1'b0;
                    end
                end
            end
            OP_END: begin
                if (!r_done) begin
                    close_req = 1'b1;
                    n_done    = 1'b1;
                end
            end
            OP_READ: begin
                o_st_re     = 1'b1;
                n_rd.hit    = WPW'(i_read_index) < r_wp;
                n_rd.root   = (i_read_index == '0);
            end
            default: begin
            end
        endcase

        if (close_req && c_cl != '0) begin
            if (c_dots && c_cl == CL_W'(1)) begin
                // "." is dropped
            end else if (c_dots && c_cl == CL_W'(2)) begin
                // ".." climbs one level, or stays at root
                if (c_depth != '0) begin
                    n_depth = c_depth - DW'(1);
                    n_wp    = i_stk_top[WPW-1:0];
                    n_ls    = i_stk_top[WPW];
                    if (c_depth >= DW'(2)) begin
                        o_stk_ctl.fetch = 1'b1;
                    end
                end
            end else if (c_depth == DW'(MAX_DEPTH)) begin
                n_ovf = 1'b1;
            end else begin
                o_stk_ctl.push = 1'b1;
                n_depth        = c_depth + DW'(1);
                o_st_wdata     = CHAR_SLASH;
                if (pos < SW'(PATH_BYTES)) begin
                    o_st_we = 1'b1;
                    n_wp    = WPW'(pos + SW'(1));
                    n_ls    = 1'b1;
                end else begin
                    // The component itself filled the last byte if it started
                    // below capacity.
                    n_ovf = 1'b1;
                    n_wp  = WPW'(PATH_BYTES);
                    if (c_wp < WPW'(PATH_BYTES)) begin
                        n_ls = 1'b0;
                    end
                end
            end
            n_cl   = '0;
            n_dots = 1'b1;
        end

        // Drop a trailing slash unless the result is just the root.
        if (op == OP_END && !r_done && n_wp > WPW'(1) && n_ls) begin
            n_wp = n_wp - WPW'(1);
        end

        if (!i_accept) begin
            o_st_we   = 1'b0;
            o_st_re   = 1'b0;
            o_stk_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= WPW'(1);
            r_depth <= '0;
            r_cl    <= '0;
            r_dots  <= 1'b1;
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
            r_ls    <= 1'b1;
            r_rd    <= '0;
        end else if (i_accept) begin
            r_wp    <= n_wp;
            r_depth <= n_depth;
            r_cl    <= n_cl;
            r_dots  <= n_dots;
            r_done  <= n_done;
            r_ovf   <= n_ovf;
            r_ls    <= n_ls;
            r_rd    <= n_rd;
        end
    end

    assign o_length   = r_wp;
    assign o_overflow = r_ovf;
    assign o_rd_info  = r_rd;

endmodule

>>> rtl/path_normalizer.sv
// Path normalizer, top level: handshake stages around pn_ctrl, pn_store and
// pn_stack. Uses pn_pkg.
//
// The block takes one transaction per clock cycle unless a stalled output
// holds it back, and returns one result for each, in order. A result passes
// first through the control logic, which updates its state while the result
// store delivers the registered read byte, and then through the output
// register. The input stays ready while one finished result waits at the
// output. Pushed bytes and slashes go straight into a single-port-write
// result store; ".." pops a component start from a stack memory whose top
// entry is kept in a register, so no path sequence stalls. No memory is
// cleared after reset: the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module path_normalizer #(
    parameter int PATH_BYTES = pn_pkg::PATH_BYTES_DEF,
    parameter int MAX_DEPTH  = pn_pkg::MAX_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_operation,
    input  logic [7:0]                            i_char_in,
    input  logic [$clog2(PATH_BYTES)-1:0]         i_read_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [$clog2(PATH_BYTES + 1)-1:0]     o_out_length,
    output logic [7:0]                            o_read_byte,
    output logic                                  o_overflow
);
    import pn_pkg::*;

    localparam int AW  = $clog2(PATH_BYTES);
    localparam int WPW = $clog2(PATH_BYTES + 1);
    localparam int SIW = $clog2(MAX_DEPTH);

    logic           accept;
    logic           s1_adv;
    logic           r_s1_valid;
    logic           r_o_valid;
    logic [WPW-1:0] r_o_len;
    logic [7:0]     r_o_byte;
    logic           r_o_ovf;

    logic           st_we;
    logic [AW-1:0]  st_waddr;
    logic [7:0]     st_wdata;
    logic           st_re;
    logic [7:0]     st_rdata;

    t_stk_ctl       stk_ctl;
    logic [SIW-1:0] stk_wr_idx;
    logic [WPW:0]   stk_wr_data;
    logic [SIW-1:0] stk_rd_idx;
    logic [WPW:0]   stk_top;

    logic [WPW-1:0] length;
    logic           overflow;
    t_rd_info       rd_info;

    // The control state and the store read register hold the transaction in
    // the first stage until it moves to the output register.
    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    pn_ctrl #(
        .PATH_BYTES (PATH_BYTES),
        .MAX_DEPTH  (MAX_DEPTH),
        .AW         (AW),
        .WPW        (WPW),
        .SIW        (SIW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_char_in     (i_char_in),
        .i_read_index  (i_read_index),
        .o_st_we       (st_we),
        .o_st_waddr    (st_waddr),
        .o_st_wdata    (st_wdata),
        .o_st_re       (st_re),
        .o_stk_ctl     (stk_ctl),
        .o_stk_wr_idx  (stk_wr_idx),
        .o_stk_wr_data (stk_wr_data),
        .o_stk_rd_idx  (stk_rd_idx),
        .i_stk_top     (stk_top),
        .o_length      (length),
        .o_overflow    (overflow),
        .o_rd_info     (rd_info)
    );

    pn_store #(
        .PATH_BYTES (PATH_BYTES),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (i_read_index),
        .o_rdata (st_rdata)
    );

    pn_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .EW        (WPW + 1),
        .SIW       (SIW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (stk_ctl),
        .i_wr_idx  (stk_wr_idx),
        .i_wr_data (stk_wr_data),
        .i_rd_idx  (stk_rd_idx),
        .o_top     (stk_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_len <= length;
            r_o_ovf <= overflow;
            if (!rd_info.hit) begin
                r_o_byte <= '0;
            end else if (rd_info.root) begin
                r_o_byte <= CHAR_SLASH;
            end else begin
                r_o_byte <= st_rdata;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_length = r_o_len;
    assign o_read_byte  = r_o_byte;
    assign o_overflow   = r_o_ovf;

endmodule

>>> rtl/pn_checker.sv
// Port-level checks for the path normalizer, bound to the top level.
// Depends on path_normalizer and pn_pkg.
`timescale 1ns / 1ps

module pn_checker #(
    parameter int PATH_BYTES = pn_pkg::PATH_BYTES_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [$clog2(PATH_BYTES + 1)-1:0] o_out_length,
    input logic [7:0]                        o_read_byte
);
    import pn_pkg::*;

    localparam int WPW = $clog2(PATH_BYTES + 1);

    // The result always holds at least the root slash.
    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_length != '0)
        else $error("result length is zero");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_length <= WPW'(PATH_BYTES))
        else $error("result length exceeds capacity");

    // With the output register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_length) && $stable(o_read_byte))
        else $error("stalled result changed");

endmodule

bind path_normalizer pn_checker #(
    .PATH_BYTES (PATH_BYTES)
) u_pn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_length (o_out_length),
    .o_read_byte  (o_read_byte)
);

>>> tb/path_normalizer_checker.sv
// Scoreboard for the path normalizer: watches both handshake channels, predicts every result.
// Predicts each result from the accepted input transactions and compares it field by field.
// Depends on pn_pkg for operation codes and byte constants.
`timescale 1ns / 1ps

module path_normalizer_checker
    import pn_pkg::*;
#(
    parameter int PATH_BYTES = PATH_BYTES_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int IDX_W      = $clog2(PATH_BYTES),
    parameter int LEN_W      = $clog2(PATH_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [7:0]       i_char_in,
    input  logic [IDX_W-1:0] i_read_index,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [LEN_W-1:0] i_out_length,
    input  logic [7:0]       i_read_byte,
    input  logic             i_overflow,
    output int               o_pending,
    output int               o_fail_count
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       rd_data;
        logic             ovf;
    } step_result_t;

    // Shadow copy of the normalizer state.
    logic [7:0]       canon_store [PATH_BYTES];
    logic [LEN_W-1:0] frame_starts [MAX_DEPTH];
    logic [LEN_W-1:0] write_pos;
    logic [DEPTH_W-1:0] frame_depth;
    logic [9:0]       seg_len;
    logic             seg_all_dots;
    logic             path_closed;
    logic             dropped;

    step_result_t awaited_outputs [$];
    int           mismatch_total;

    function automatic void start_new_path();
        canon_store[0] = CHAR_SLASH;
        write_pos      = 1;
        frame_depth    = 0;
        seg_len        = 0;
        seg_all_dots   = 1'b1;
        path_closed    = 1'b0;
        dropped        = 1'b0;
    endfunction

    // Finish the component being received: drop ".", climb on "..", keep the rest.
    function automatic void close_segment();
        int pos;
        if (seg_len == 0) begin
            return;
        end
        if (seg_all_dots && seg_len == 1) begin
            // A single dot names the current directory and leaves no trace.
        end else if (seg_all_dots && seg_len == 2) begin
            if (frame_depth > 0) begin
                frame_depth = frame_depth - 1'b1;
                write_pos   = frame_starts[frame_depth];
            end
        end else if (frame_depth >= MAX_DEPTH) begin
            dropped = 1'b1;
        end else begin
            frame_starts[frame_depth] = write_pos;
            frame_depth = frame_depth + 1'b1;
            pos = int'(write_pos) + int'(seg_len);
            if (pos < PATH_BYTES) begin
                canon_store[pos] = CHAR_SLASH;
                write_pos = LEN_W'(pos + 1);
            end else begin
                dropped   = 1'b1;
                write_pos = LEN_W'(PATH_BYTES);
            end
        end
        seg_len      = 0;
        seg_all_dots = 1'b1;
    endfunction

    function automatic step_result_t normalize_step(input logic [1:0] op,
                                                    input logic [7:0] ch,
                                                    input logic [IDX_W-1:0] idx);
        step_result_t res;
        int           pos;
        res.rd_data = 8'h00;
        case (op)
            OP_PUSH: begin
                if (path_closed) begin
                    start_new_path();
                end
                if (ch == CHAR_SLASH) begin
                    close_segment();
                end else if (seg_len >= COMP_MAX) begin
                    dropped = 1'b1;
                end else begin
                    // Bytes past capacity are lost but still lengthen the component.
                    pos = int'(write_pos) + int'(seg_len);
                    if (pos < PATH_BYTES) begin
                        canon_store[pos] = ch;
                    end else begin
                        dropped = 1'b1;
                    end
                    seg_len = seg_len + 1'b1;
                    if (ch != CHAR_DOT) begin
                        seg_all_dots = 1'b0;
                    end
                end
            end
            OP_END: begin
                if (!path_closed) begin
                    close_segment();
                    if (write_pos > 1 && write_pos <= PATH_BYTES &&
                        canon_store[write_pos - 1'b1] == CHAR_SLASH) begin
                        write_pos = write_pos - 1'b1;
                    end
                    path_closed = 1'b1;
                end
            end
            OP_READ: begin
                if (idx < write_pos && idx < PATH_BYTES) begin
                    res.rd_data = canon_store[idx];
                end
            end
            default: begin
            end
        endcase
        res.len = write_pos;
        res.ovf = dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        step_result_t want;
        step_result_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < PATH_BYTES; i++) begin
                canon_store[i] = 8'h00;
            end
            start_new_path();
            awaited_outputs.delete();
            mismatch_total = 0;
        end else begin
            // A result never leaves in the cycle its transaction is taken, so
            // the output side is handled before this edge's input.
            if (i_out_valid && i_out_ready) begin
                got = '{len: i_out_length, rd_data: i_read_byte, ovf: i_overflow};
                if (awaited_outputs.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("%0t: unexpected result len=%0d byte=%02h ovf=%b",
                                 $realtime, got.len, got.rd_data, got.ovf);
                    end
                end else begin
                    want = awaited_outputs.pop_front();
                    if (got.len !== want.len || got.rd_data !== want.rd_data ||
                        got.ovf !== want.ovf) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("%0t: mismatch exp len=%0d byte=%02h ovf=%b",
                                     $realtime, want.len, want.rd_data, want.ovf);
                            $display("%0t:          got len=%0d byte=%02h ovf=%b",
                                     $realtime, got.len, got.rd_data, got.ovf);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_outputs.push_back(normalize_step(i_operation, i_char_in,
                                                         i_read_index));
            end
        end
        o_pending    <= awaited_outputs.size();
        o_fail_count <= mismatch_total;
    end

endmodule

>>> tb/path_normalizer_tb.sv
// Top of the path normalizer testbench: clock, reset, stimulus and the verdict.
// Instantiates path_normalizer and path_normalizer_checker; uses pn_pkg.
`timescale 1ns / 1ps

module path_normalizer_tb;
    import pn_pkg::*;

    localparam int PATH_BYTES   = PATH_BYTES_DEF;
    localparam int MAX_DEPTH    = MAX_DEPTH_DEF;
    localparam int IDX_W        = $clog2(PATH_BYTES);
    localparam int LEN_W        = $clog2(PATH_BYTES + 1);
    localparam int RANDOM_ITEMS = 950;
    localparam int LONG_HOLD    = 100;
    localparam int LIMIT_CYCLES = 1000000;

    // Operation code that the block does not define; it must change nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] CHAR_A    = "a";

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       operation;
    logic [7:0]       char_in;
    logic [IDX_W-1:0] read_index;
    logic             out_valid;
    logic             out_ready;
    logic [LEN_W-1:0] out_length;
    logic [7:0]       read_byte;
    logic             overflow;

    int pending;
    int fail_count;
    int cycle_count;
    int sent_items;
    int hold_requests;
    int holds_done;
    bit burst;

    path_normalizer #(
        .PATH_BYTES (PATH_BYTES),
        .MAX_DEPTH  (MAX_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_operation  (operation),
        .i_char_in    (char_in),
        .i_read_index (read_index),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_length (out_length),
        .o_read_byte  (read_byte),
        .o_overflow   (overflow)
    );

    path_normalizer_checker #(
        .PATH_BYTES (PATH_BYTES),
        .MAX_DEPTH  (MAX_DEPTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_operation  (operation),
        .i_char_in    (char_in),
        .i_read_index (read_index),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_length (out_length),
        .i_read_byte  (read_byte),
        .i_overflow   (overflow),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("path_normalizer regression: fail");
        $finish;
    end

    // Output side: random back-pressure, plus long holds on request so the
    // block fills up and has to stall its input.
    initial begin
        int  left;
        bit  level;
        out_ready  = 1'b0;
        holds_done = 0;
        left       = 0;
        level      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                holds_done++;
                left = 0;
            end else begin
                if (left == 0) begin
                    case ($urandom_range(99)) inside
                        [0:49]:  begin level = 1'b1; left = $urandom_range(1, 30); end
                        [50:89]: begin level = 1'b0; left = $urandom_range(1, 3);  end
                        [90:97]: begin level = 1'b0; left = $urandom_range(4, 12); end
                        default: begin level = 1'b0; left = $urandom_range(20, 40); end
                    endcase
                end
                out_ready <= level;
                left--;
            end
        end
    end

    // One input transaction, preceded by a random gap unless in a burst.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        int r;
        r = $urandom_range(99);
        if (burst || r < 55) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid   <= 1'b1;
        operation  <= op;
        char_in    <= ch;
        read_index <= idx;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic push_char(input logic [7:0] ch);
        send_item(OP_PUSH, ch, IDX_W'($urandom));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endtask

    task automatic end_path();
        send_item(OP_END, 8'($urandom), IDX_W'($urandom));
    endtask

    task automatic read_at(input int idx);
        send_item(OP_READ, 8'($urandom), IDX_W'(idx));
    endtask

    // Any byte except the separator, biased toward letters and dots.
    function automatic logic [7:0] seg_char();
        logic [7:0] b;
        int         r;
        r = $urandom_range(99);
        if (r < 40) begin
            b = CHAR_A + 8'($urandom_range(25));
        end else if (r < 65) begin
            b = CHAR_DOT;
        end else begin
            b = 8'($urandom_range(255));
            while (b == CHAR_SLASH) b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic random_path();
        int n_comp;
        int kind;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) push_char(CHAR_SLASH);
        end
        n_comp = $urandom_range(1, 8);
        for (int k = 0; k < n_comp; k++) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                push_text(".");
            end else if (kind < 35) begin
                push_text("..");
            end else if (kind < 40) begin
                push_text("...");
            end else begin
                repeat ($urandom_range(1, 6)) push_char(seg_char());
            end
            if (k < n_comp - 1 || $urandom_range(1) == 0) begin
                repeat (($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1)
                    push_char(CHAR_SLASH);
            end
        end
        if ($urandom_range(9) != 0) begin
            end_path();
            if ($urandom_range(7) == 0) begin
                end_path();
            end
        end
        repeat ($urandom_range(0, 5)) begin
            read_at(($urandom_range(4) != 0) ? $urandom_range(24) : $urandom_range(511));
        end
    endtask

    // Deep path: fills the store to capacity and then the component stack,
    // and climbs two levels back out of it.
    task automatic deep_path();
        hold_requests++;
        repeat (MAX_DEPTH + 2) begin
            push_char(CHAR_A + 8'($urandom_range(25)));
            push_char(CHAR_SLASH);
        end
        push_text("../../x");
        read_at(PATH_BYTES - 1);
        read_at(PATH_BYTES - 2);
        end_path();
        read_at(PATH_BYTES - 1);
        read_at(0);
        read_at($urandom_range(511));
    endtask

    initial begin
        int base;
        int path_count;
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_PUSH;
        char_in       = 8'h00;
        read_index    = '0;
        sent_items    = 0;
        hold_requests = 0;
        burst         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads at reset, the unused code, empty and repeated ends,
        // root climbs, extreme bytes and a "..." component.
        read_at(0);
        read_at(511);
        send_item(OP_UNUSED, 8'hFF, '1);
        end_path();
        end_path();
        read_at(0);
        push_text("/..//./");
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CHAR_SLASH);
        push_text("...");
        end_path();
        read_at(1);
        read_at(2);
        read_at(3);

        // The deep path counts toward the total, so the whole run stays near
        // the intended number of transactions.
        base       = sent_items;
        path_count = 0;
        while (sent_items - base < RANDOM_ITEMS) begin
            burst = ($urandom_range(4) == 0);
            if (path_count == 6) begin
                deep_path();
            end else if ($urandom_range(99) < 85) begin
                random_path();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                              IDX_W'($urandom_range(511)));
                end
            end
            path_count++;
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("path_normalizer regression: pass");
        end else begin
            $display("path_normalizer regression: fail");
        end
        $finish;
    end

endmodule
